// ===== rtl/core/bffi_pkg.sv =====
`default_nettype none
package bffi_pkg;
  localparam logic [63:0] DefaultSeed = 64'hDEADBEEFCAFEBABE;
  localparam logic [31:0] GapReset = 32'd100000;
  typedef enum logic [3:0] {
    ModeNone = 4'd0, ModeReplay = 4'd1, ModePayload = 4'd2, ModeAuth = 4'd3,
    ModeFresh = 4'd4, ModeKeyConf = 4'd5, ModeFlood = 4'd6, ModeSigFuzz = 4'd7,
    ModeDowngrade = 4'd8, ModeHarvest = 4'd9, ModeTiming = 4'd10
  } mode_e;
  typedef enum logic [1:0] {
    RegMode = 2'd0, RegSeed = 2'd1, RegGap = 2'd2
  } reg_e;
  function automatic logic [63:0] xs_step(input logic [63:0] w);
    logic [63:0] x;
    x = w ^ (w << 13);
    x = x ^ (x >> 7);
    x = x ^ (x << 17);
    return x;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/bffi_if.sv =====
`default_nettype none
interface bffi_in_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic [12:0] byte_index;
  logic [13:0] frame_len;
  logic [63:0] now_ns;
  modport source(output valid, data_byte, byte_index, frame_len, now_ns, input ready);
  modport sink(input valid, data_byte, byte_index, frame_len, now_ns, output ready);
endinterface

interface bffi_out_if;
  logic valid;
  logic ready;
  logic [7:0] out_byte;
  logic frame_modified;
  logic last_byte;
  logic [31:0] injected_count;
  modport source(output valid, out_byte, frame_modified, last_byte, injected_count,
                 input ready);
  modport sink(input valid, out_byte, frame_modified, last_byte, injected_count,
               output ready);
endinterface

interface bffi_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bus_frame_fault_injector.sv =====
`default_nettype none
// channel  dir  beat payload
// in_ch    in   data_byte, byte_index, frame_len, now_ns
// out_ch   out  out_byte, frame_modified, last_byte, injected_count
// cfg_ch   in   index (0 mode, 1 seed, 2 gap), data
// a byte goes through accept, mutate into the result register and result offered;
// a payload-mode frame start adds a shift-subtract modulo of
// 64 steps, one bit per cycle
// reset clears control state (seed and gap load their defaults); replay memory is undefined until captured
// in_ch is ready only in idle, so a waiting result or a running modulo stalls it
module bus_frame_fault_injector #(
  parameter int MAX_FRAME_BYTES = 8192
) (
  input wire clk_i,
  input wire rst_ni,
  bffi_in_if.sink in_ch,
  bffi_out_if.source out_ch,
  bffi_cfg_if.sink cfg_ch
);
  localparam int AW = $clog2(MAX_FRAME_BYTES);
  localparam logic [2:0] S_IDLE = 3'd0, S_MOD = 3'd1, S_EMIT = 3'd2, S_OUT = 3'd3;

  logic [2:0] st_q, st_d;
  logic [3:0] amode_q, fmode_q;
  logic [63:0] rng_q;
  logic [31:0] gap_q, inj_q;
  logic [13:0] rlen_q;
  logic [2:0] pcnt_q;
  logic [63:0] ltime_q;
  logic seen_q;
  logic [15:0] tgt_q;
  logic fmod_q, fcap_q, fsub_q;
  logic [7:0] mem [MAX_FRAME_BYTES];
  logic [7:0] rd_q;
  // held item
  logic [7:0] d_q;
  logic [12:0] idx_q;
  logic [13:0] len_q;
  // modulo unit
  logic [63:0] num_q;
  logic [16:0] rem_q, div_q;
  logic [6:0] cnt_q;
  logic [7:0] ob_q;
  logic lb_q, om_q;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = (st_q == S_IDLE);
  assign out_ch.valid = (st_q == S_OUT);
  assign out_ch.out_byte = ob_q;
  assign out_ch.frame_modified = om_q;
  assign out_ch.last_byte = lb_q;
  assign out_ch.injected_count = inj_q;

  wire acc = in_ch.valid && in_ch.ready;
  wire [13:0] len_i = in_ch.frame_len;
  wire fits = ({18'd0, len_i} <= 32'(MAX_FRAME_BYTES));
  wire [63:0] dt = in_ch.now_ns - ltime_q;
  wire first = !seen_q || (dt > {32'd0, gap_q});
  // capture of byte zero
  wire cap0 = (in_ch.byte_index == 13'd0) && (amode_q == bffi_pkg::ModeReplay) &&
              first && (pcnt_q == 3'd0) && fits;
  wire [63:0] nr = bffi_pkg::xs_step(rng_q);
  wire [17:0] trial = {rem_q, num_q[63]};
  wire ge = trial >= {1'b0, div_q};
  wire [16:0] rnext = ge ? 17'(trial - {1'b0, div_q}) : trial[16:0];
  wire idx_in = ({1'b0, idx_q} < len_q);
  wire [13:0] nsf = (len_q >= 14'd16) ? 14'd16 : 14'(len_q - 14'd1);

  always_ff @(posedge clk_i) begin
    if (acc && ((fcap_q && in_ch.byte_index != 13'd0) || cap0) &&
        {1'b0, in_ch.byte_index} < in_ch.frame_len &&
        32'(in_ch.byte_index) < 32'(MAX_FRAME_BYTES))
      mem[AW'(in_ch.byte_index)] <= in_ch.data_byte;
    if (acc && 32'(in_ch.byte_index) < 32'(MAX_FRAME_BYTES))
      rd_q <= mem[AW'(in_ch.byte_index)];
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (acc) st_d = S_EMIT;
      S_MOD: if (cnt_q == 7'd63) st_d = S_EMIT;
      S_EMIT: st_d = S_OUT;
      S_OUT: if (out_ch.ready) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
    if (st_q == S_IDLE && acc && in_ch.byte_index == 13'd0 &&
        in_ch.valid && amode_q == bffi_pkg::ModePayload && len_i > 14'd4 && fits)
      st_d = S_MOD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; amode_q <= '0; fmode_q <= '0; rng_q <= bffi_pkg::DefaultSeed;
      gap_q <= bffi_pkg::GapReset; inj_q <= '0; rlen_q <= '0; pcnt_q <= '0;
      ltime_q <= '0; seen_q <= 1'b0; tgt_q <= '0;
      fmod_q <= 1'b0; fcap_q <= 1'b0; fsub_q <= 1'b0; cnt_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          bffi_pkg::RegMode: amode_q <= cfg_ch.data[3:0];
          bffi_pkg::RegSeed: rng_q <= (cfg_ch.data == 64'd0) ? bffi_pkg::DefaultSeed
                                                            : cfg_ch.data;
          bffi_pkg::RegGap: gap_q <= cfg_ch.data[31:0];
          default: ;
        endcase
      end
      if (acc) begin
        d_q <= in_ch.data_byte; idx_q <= in_ch.byte_index; len_q <= len_i;
        if (in_ch.byte_index == 13'd0) begin
          logic ci, fm, fc, fs;
          logic [15:0] tg;
          logic [31:0] ib;
          ib = 32'd0;
          ci = 1'b0;
          fm = 1'b0;
          fc = 1'b0;
          fs = 1'b0;
          tg = '0;
          seen_q <= 1'b1; ltime_q <= in_ch.now_ns; fmode_q <= amode_q;
          case (amode_q)
            bffi_pkg::ModeReplay: if (first) begin
              logic [2:0] pc;
              logic [13:0] rl;
              rl = rlen_q;
              if (pcnt_q == 3'd0) begin
                rl = fits ? len_i : 14'd0;
                fc = fits;
              end
              pc = (pcnt_q < 3'd4) ? 3'(pcnt_q + 3'd1) : pcnt_q;
              rlen_q <= rl; pcnt_q <= pc;
              if (pc >= 3'd4 && fits && rl != 14'd0 && rl == len_i) begin
                fm = 1'b1; fs = 1'b1; ci = 1'b1;
              end
            end
            bffi_pkg::ModePayload: if (len_i > 14'd4 && fits) begin
              rng_q <= nr; num_q <= nr; rem_q <= '0; cnt_q <= '0;
              div_q <= {len_i - 14'd3, 3'd0}; fm = 1'b1; ci = 1'b1;
            end
            bffi_pkg::ModeAuth: if (len_i > 14'd4 && fits) begin
              rng_q <= nr; tg = 16'(len_i - 14'd1 - {12'd0, nr[1:0]});
              fm = 1'b1; ci = 1'b1;
            end
            bffi_pkg::ModeFresh: if (len_i >= 14'd10 && fits) begin
              fm = 1'b1; ci = 1'b1; end
            bffi_pkg::ModeKeyConf: if (len_i > 14'd10 && fits) begin
              fm = 1'b1; ci = 1'b1; end
            bffi_pkg::ModeSigFuzz: if (len_i > 14'd4 && fits) begin
              fm = 1'b1; ci = 1'b1; end
            bffi_pkg::ModeDowngrade: if (len_i >= 14'd2 && fits) begin
              fm = 1'b1; ci = 1'b1; end
            bffi_pkg::ModeFlood, bffi_pkg::ModeHarvest, bffi_pkg::ModeTiming: ci = 1'b1;
            default: ;
          endcase
          fmod_q <= fm; fcap_q <= fc; fsub_q <= fs; tgt_q <= tg;
          ib = inj_q;
          if (ci && inj_q != 32'hFFFFFFFF) ib = inj_q + 32'd1;
          inj_q <= ib;
        end
      end
      if (st_q == S_MOD) begin
        num_q <= {num_q[62:0], 1'b0}; rem_q <= rnext; cnt_q <= 7'(cnt_q + 7'd1);
        if (cnt_q == 7'd63) tgt_q <= rnext[15:0];
      end
      if (st_q == S_EMIT) begin
        logic [7:0] o;
        o = d_q;
        if (fmod_q && idx_in) begin
          case (fmode_q)
            bffi_pkg::ModeReplay:
              if (fsub_q && 32'(idx_q) < 32'(MAX_FRAME_BYTES)) o = rd_q;
            bffi_pkg::ModePayload:
              if (idx_q == tgt_q[15:3]) o = o ^ (8'd1 << tgt_q[2:0]);
            bffi_pkg::ModeAuth: if ({3'd0, idx_q} == tgt_q) o = ~o;
            bffi_pkg::ModeFresh: if (idx_q >= 13'd2 && idx_q <= 13'd9) o = 8'd0;
            bffi_pkg::ModeKeyConf: if (idx_q >= 13'd2) begin
              o = o ^ nr[7:0]; rng_q <= nr; end
            bffi_pkg::ModeSigFuzz: if ({1'b0, idx_q} >= 14'(len_q - nsf)) begin
              o = nr[7:0]; rng_q <= nr; end
            bffi_pkg::ModeDowngrade: if (idx_q == 13'd0) o = {2'b01, o[5:0]};
            default: ;
          endcase
        end
        ob_q <= o; om_q <= fmod_q; lb_q <= (14'({1'b0, idx_q} + 14'd1) == len_q);
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/bffi_checker.sv =====
`default_nettype none
module bffi_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire in_valid_i,
  input wire in_ready_i,
  input wire out_valid_i,
  input wire out_ready_i,
  input wire [31:0] inj_i
);
  // one byte in flight at a time
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("input ready while result waits");
  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i) else $error("ready after accept");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i && $stable(inj_i))
    else $error("result dropped");
  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |=> out_valid_i ? 1'b1 : (inj_i >= $past(inj_i)))
    else $error("count decreased");
endmodule

bind bus_frame_fault_injector bffi_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready),
  .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready), .inj_i(out_ch.injected_count)
);
`default_nettype wire
